// ===== rtl/connection_table_port_allocator_top_defines.svh =====
// ----------------------------------------------------------------------------
// Connection table assertion macros
// Concurrent checks on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef CONNECTION_TABLE_PORT_ALLOCATOR_TOP_DEFINES_SVH
`define CONNECTION_TABLE_PORT_ALLOCATOR_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

`define CTPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define CTPA_ASSERT_IMPL(lbl, ante, cons, msg) \
  `CTPA_ASSERT(lbl, (ante) |-> (cons), msg)

`define CTPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  `CTPA_ASSERT(lbl, (ante) |=> (cons), msg)

`else

`define CTPA_ASSERT(lbl, prop, msg)
`define CTPA_ASSERT_IMPL(lbl, ante, cons, msg)
`define CTPA_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/ctpa_pkg.sv =====
// ----------------------------------------------------------------------------
// ctpa_pkg
// Types and constants shared by the connection table modules.
// ----------------------------------------------------------------------------
package ctpa_pkg;

  localparam int MAX_SLOT_W = 6;   // up to 64 slots
  localparam int MAX_PORT_W = 8;
  localparam int TRY_W      = 9;
  localparam int MAX_TRIES  = 256;

  localparam logic [7:0] RST_MAX_BIND   = 8'd31;
  localparam logic [7:0] RST_PORT_LIMIT = 8'd63;
  localparam logic [7:0] RST_NEXT_PORT  = 8'd32;

  typedef enum logic [1:0] {
    KIND_FIND    = 2'd0,
    KIND_OPEN    = 2'd1,
    KIND_CONNECT = 2'd2,
    KIND_CLOSE   = 2'd3
  } ctpa_kind_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_MATCH = 2'd1,
    STAT_NO_PORT  = 2'd2,
    STAT_NO_SLOT  = 2'd3
  } ctpa_status_e;

  typedef enum logic [0:0] {
    REG_MAX_BIND   = 1'b0,
    REG_PORT_LIMIT = 1'b1
  } ctpa_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND_RD,
    ST_FIND_CMP,
    ST_OPEN,
    ST_CONN_STEP,
    ST_CONN_TEST,
    ST_RESP
  } ctpa_state_e;

  typedef struct packed {
    logic                  set;
    logic                  clr;
    logic [MAX_SLOT_W-1:0] idx;
    logic [MAX_PORT_W-1:0] port;
  } ctpa_lane_cmd_t;

  typedef struct packed {
    ctpa_status_e status;
    logic [3:0]   slot;
    logic [7:0]   port;
  } ctpa_res_t;

endpackage

// ===== rtl/ctpa_in_if.sv =====
// ----------------------------------------------------------------------------
// ctpa_in_if
// Request channel: one beat carries one table operation.
// ----------------------------------------------------------------------------
interface ctpa_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] ident;
  logic [31:0] match_mask;
  logic [3:0]  slot_sel;

  modport source (output valid, kind, ident, match_mask, slot_sel, input ready);
  modport sink   (input valid, kind, ident, match_mask, slot_sel, output ready);
endinterface

// ===== rtl/ctpa_out_if.sv =====
// ----------------------------------------------------------------------------
// ctpa_out_if
// Response channel: one beat per operation.
// ----------------------------------------------------------------------------
interface ctpa_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [3:0] slot_out;
  logic [7:0] port_out;

  modport source (output valid, status, slot_out, port_out, input ready);
  modport sink   (input valid, status, slot_out, port_out, output ready);
endinterface

// ===== rtl/connection_table_port_allocator_top.sv =====
// One operation in flight at a time: a request is accepted only while the
// sequencer is idle. Find and open step a single slot scan pointer;
// connect walks the port counter and then runs the open scan.
// Reset: all slots closed, last-given slot 0, next port 32, registers 31/63.
// ----------------------------------------------------------------------------
// connection_table_port_allocator_top
// Connection slot table with masked find, round-robin open, ephemeral port
// search and close. Holds configuration and the output stage.
// ----------------------------------------------------------------------------
module connection_table_port_allocator_top import ctpa_pkg::*; #(
  parameter int SLOTS     = 16,
  parameter int PORT_LSB  = 14,
  parameter int PORT_BITS = 6
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [0:0]   cfg_idx_i,
  input  logic [7:0]   cfg_wdata_i,
  ctpa_in_if.sink      in_i,
  ctpa_out_if.source   out_o
);

  // port field is clipped at bit 31
  localparam int FIELD_W = (PORT_LSB + PORT_BITS > 32) ? 32 - PORT_LSB : PORT_BITS;
  localparam int SW      = $clog2(SLOTS);

  logic [7:0]         max_bind_q, port_limit_q;
  logic               out_valid_q;
  ctpa_res_t          out_q;

  logic [SLOTS-1:0]   open;
  logic               hit;
  logic [FIELD_W-1:0] cand;
  ctpa_lane_cmd_t     lane_cmd;
  logic               ram_we, ram_re;
  logic [SW-1:0]      ram_waddr, ram_raddr;
  logic [31:0]        ram_wdata, ram_rdata;
  logic               idle, res_valid, res_take;
  ctpa_res_t          res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bind_q   <= RST_MAX_BIND;
      port_limit_q <= RST_PORT_LIMIT;
    end else if (cfg_we_i) begin
      unique case (ctpa_reg_e'(cfg_idx_i))
        REG_MAX_BIND:   max_bind_q   <= cfg_wdata_i;
        REG_PORT_LIMIT: port_limit_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // output stage: result beat waits here while the next request runs
  assign res_take = res_valid && (!out_valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.status   = out_q.status;
  assign out_o.slot_out = out_q.slot;
  assign out_o.port_out = out_q.port;
  assign in_i.ready     = idle;

  ctpa_ram #(
    .WIDTH (32),
    .DEPTH (SLOTS)
  ) u_ident_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ctpa_port_lanes #(
    .SLOTS   (SLOTS),
    .FIELD_W (FIELD_W)
  ) u_lanes (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (lane_cmd),
    .cand_i (cand),
    .open_o (open),
    .hit_o  (hit)
  );

  ctpa_seq #(
    .SLOTS    (SLOTS),
    .PORT_LSB (PORT_LSB),
    .FIELD_W  (FIELD_W)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (in_i.valid && idle),
    .kind_i       (ctpa_kind_e'(in_i.kind)),
    .ident_i      (in_i.ident),
    .mask_i       (in_i.match_mask),
    .sel_i        (in_i.slot_sel),
    .max_bind_i   (max_bind_q),
    .port_limit_i (port_limit_q),
    .open_i       (open),
    .hit_i        (hit),
    .cand_o       (cand),
    .lane_cmd_o   (lane_cmd),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .idle_o       (idle),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_take_i   (res_take)
  );

endmodule

// ===== rtl/ctpa_ram.sv =====
// ----------------------------------------------------------------------------
// ctpa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ctpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ctpa_port_lanes.sv =====
// ----------------------------------------------------------------------------
// ctpa_port_lanes
// Per-slot open flag and destination-port field, with a parallel test of a
// candidate port against every open slot.
// ----------------------------------------------------------------------------
module ctpa_port_lanes import ctpa_pkg::*; #(
  parameter int SLOTS   = 16,
  parameter int FIELD_W = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctpa_lane_cmd_t     cmd_i,
  input  logic [FIELD_W-1:0] cand_i,
  output logic [SLOTS-1:0]   open_o,
  output logic               hit_o
);

  localparam int SW = $clog2(SLOTS);

  logic [SLOTS-1:0]   open_q;
  logic [FIELD_W-1:0] port_q [SLOTS];
  logic [SW-1:0]      idx;
  logic [SLOTS-1:0]   lane_hit;

  assign idx = cmd_i.idx[SW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else if (cmd_i.set) begin
      open_q[idx] <= 1'b1;
    end else if (cmd_i.clr) begin
      open_q[idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.set) begin
      port_q[idx] <= cmd_i.port[FIELD_W-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      lane_hit[i] = open_q[i] && (port_q[i] == cand_i);
    end
  end

  assign hit_o  = |lane_hit;
  assign open_o = open_q;

endmodule

// ===== rtl/ctpa_seq.sv =====
// ----------------------------------------------------------------------------
// ctpa_seq
// Operation sequencer: slot scan for find and open, port walk for connect,
// close, and result hold until the output stage takes it.
// ----------------------------------------------------------------------------
`include "connection_table_port_allocator_top_defines.svh"

module ctpa_seq import ctpa_pkg::*; #(
  parameter int SLOTS     = 16,
  parameter int PORT_LSB  = 14,
  parameter int FIELD_W   = 6
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  ctpa_kind_e               kind_i,
  input  logic [31:0]              ident_i,
  input  logic [31:0]              mask_i,
  input  logic [3:0]               sel_i,
  input  logic [7:0]               max_bind_i,
  input  logic [7:0]               port_limit_i,
  input  logic [SLOTS-1:0]         open_i,
  input  logic                     hit_i,
  output logic [FIELD_W-1:0]       cand_o,
  output ctpa_lane_cmd_t           lane_cmd_o,
  output logic                     ram_we_o,
  output logic [$clog2(SLOTS)-1:0] ram_waddr_o,
  output logic [31:0]              ram_wdata_o,
  output logic                     ram_re_o,
  output logic [$clog2(SLOTS)-1:0] ram_raddr_o,
  input  logic [31:0]              ram_rdata_i,
  output logic                     idle_o,
  output logic                     res_valid_o,
  output ctpa_res_t                res_o,
  input  logic                     res_take_i
);

  localparam int SW = $clog2(SLOTS);

  function automatic logic [SW-1:0] wrap_inc(input logic [SW-1:0] v);
    logic [SW-1:0] r;
    r = (v == SW'(SLOTS - 1)) ? '0 : v + SW'(1);
    return r;
  endfunction

  ctpa_state_e       state_q, state_d;
  ctpa_kind_e        kind_q, kind_d;
  logic [31:0]       ident_q, ident_d;
  logic [31:0]       mask_q, mask_d;
  logic [SW-1:0]     idx_q, idx_d;
  logic [SW-1:0]     last_q, last_d;
  logic [7:0]        np_q, np_d;
  logic [7:0]        start_q, start_d;
  logic [TRY_W-1:0]  tries_q, tries_d;
  ctpa_res_t         res_q, res_d;

  logic              idx_open, find_match, idx_last, open_full;
  logic              tries_done, wrap_start, over_limit, sel_ok;
  logic [7:0]        np_inc, bind_next;
  logic [SW+3:0]     idx_ext, sel_ext;
  logic [3:0]        idx_slot;
  logic [SW-1:0]     sel_idx;

  assign idx_open   = open_i[idx_q];
  assign find_match = idx_open && (((ram_rdata_i ^ ident_q) & mask_q) == '0);
  assign idx_last   = (idx_q == SW'(SLOTS - 1));
  assign open_full  = (idx_q == last_q);
  assign np_inc     = np_q + 8'd1;
  assign bind_next  = max_bind_i + 8'd1;
  assign tries_done = (tries_q == TRY_W'(MAX_TRIES));
  assign wrap_start = (np_inc == start_q);
  assign over_limit = (np_inc > port_limit_i);
  assign sel_ok     = (int'(sel_i) < SLOTS);
  assign idx_ext    = {4'b0000, idx_q};
  assign idx_slot   = idx_ext[3:0];
  assign sel_ext    = {{SW{1'b0}}, sel_i};
  assign sel_idx    = sel_ext[SW-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          unique case (kind_i)
            KIND_FIND:    state_d = ST_FIND_RD;
            KIND_OPEN:    state_d = ST_OPEN;
            KIND_CONNECT: state_d = ST_CONN_STEP;
            KIND_CLOSE:   state_d = ST_RESP;
            default:      state_d = ST_IDLE;
          endcase
        end
      end
      ST_FIND_RD:  state_d = ST_FIND_CMP;
      ST_FIND_CMP: begin
        state_d = (find_match || idx_last) ? ST_RESP : ST_FIND_RD;
      end
      ST_OPEN: begin
        if (open_full || !idx_open) begin
          state_d = ST_RESP;
        end
      end
      ST_CONN_STEP: begin
        state_d = (tries_done || wrap_start) ? ST_RESP : ST_CONN_TEST;
      end
      ST_CONN_TEST: begin
        priority if (hit_i) begin
          state_d = ST_CONN_STEP;
        end else if (np_q == start_q) begin
          state_d = ST_RESP;
        end else begin
          state_d = ST_OPEN;
        end
      end
      ST_RESP: begin
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and unit control
  always_comb begin
    kind_d      = kind_q;
    ident_d     = ident_q;
    mask_d      = mask_q;
    idx_d       = idx_q;
    last_d      = last_q;
    np_d        = np_q;
    start_d     = start_q;
    tries_d     = tries_q;
    res_d       = res_q;
    lane_cmd_o  = '0;
    ram_we_o    = 1'b0;
    ram_re_o    = 1'b0;
    ram_wdata_o = ident_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          kind_d     = kind_i;
          ident_d    = ident_i;
          mask_d     = mask_i;
          start_d    = np_q;
          tries_d    = '0;
          res_d.port = 8'd0;
          unique case (kind_i)
            KIND_FIND: idx_d = '0;
            KIND_OPEN: idx_d = wrap_inc(last_q);
            KIND_CLOSE: begin
              // out-of-range slot is ignored but still echoed
              lane_cmd_o.clr = sel_ok;
              lane_cmd_o.idx = MAX_SLOT_W'(sel_idx);
              res_d.status   = STAT_OK;
              res_d.slot     = sel_i;
            end
            default: ;
          endcase
        end
      end
      ST_FIND_RD: begin
        ram_re_o = 1'b1;
      end
      ST_FIND_CMP: begin
        priority if (find_match) begin
          res_d.status = STAT_OK;
          res_d.slot   = idx_slot;
        end else if (idx_last) begin
          res_d.status = STAT_NO_MATCH;
          res_d.slot   = 4'd0;
        end else begin
          idx_d = wrap_inc(idx_q);
        end
      end
      ST_OPEN: begin
        // the slot given last is never rechecked
        priority if (open_full) begin
          res_d.status = STAT_NO_SLOT;
          res_d.slot   = 4'd0;
        end else if (!idx_open) begin
          ram_we_o        = 1'b1;
          lane_cmd_o.set  = 1'b1;
          lane_cmd_o.idx  = MAX_SLOT_W'(idx_q);
          lane_cmd_o.port = MAX_PORT_W'(ident_q[PORT_LSB +: FIELD_W]);
          last_d          = idx_q;
          res_d.status    = STAT_OK;
          res_d.slot      = idx_slot;
        end else begin
          idx_d = wrap_inc(idx_q);
        end
      end
      ST_CONN_STEP: begin
        priority if (tries_done) begin
          res_d.status = STAT_NO_PORT;
          res_d.slot   = 4'd0;
          res_d.port   = np_q;
        end else if (wrap_start) begin
          np_d         = np_inc;
          res_d.status = STAT_NO_PORT;
          res_d.slot   = 4'd0;
          res_d.port   = np_inc;
        end else begin
          np_d    = over_limit ? bind_next : np_inc;
          tries_d = tries_q + TRY_W'(1);
        end
      end
      ST_CONN_TEST: begin
        res_d.port = np_q;
        if (!hit_i) begin
          if (np_q == start_q) begin
            res_d.status = STAT_NO_PORT;
            res_d.slot   = 4'd0;
          end else begin
            ident_d[PORT_LSB +: FIELD_W] = np_q[FIELD_W-1:0];
            idx_d = wrap_inc(last_q);
          end
        end
      end
      ST_RESP: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      last_q  <= '0;
      np_q    <= RST_NEXT_PORT;
    end else begin
      state_q <= state_d;
      last_q  <= last_d;
      np_q    <= np_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    ident_q <= ident_d;
    mask_q  <= mask_d;
    idx_q   <= idx_d;
    start_q <= start_d;
    tries_q <= tries_d;
    res_q   <= res_d;
  end

  assign cand_o      = np_q[FIELD_W-1:0];
  assign ram_waddr_o = idx_q;
  assign ram_raddr_o = idx_q;
  assign idle_o      = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_RESP);
  assign res_o       = res_q;

  `CTPA_ASSERT_NEXT(a_claim_opens, state_q == ST_OPEN && !open_full && !idx_open, open_i[last_q], "claimed slot not marked open")
  `CTPA_ASSERT_IMPL(a_conn_port_inserted, state_q == ST_OPEN && kind_q == KIND_CONNECT, ident_q[PORT_LSB +: FIELD_W] == np_q[FIELD_W-1:0], "connect identifier lacks chosen port")
  `CTPA_ASSERT_IMPL(a_cand_in_range, state_q == ST_CONN_TEST, np_q <= port_limit_i || np_q == bind_next, "candidate port outside ephemeral range")

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Connection table testbench
// Drives find, open, connect and close beats with random gaps and a long
// receiver hold-off. A local copy of the slot table, the port counter and
// the registers predicts every reply, which is checked field by field.
// The registers are rewritten between phases.
// ----------------------------------------------------------------------------
module testbench;
  import ctpa_pkg::*;

  localparam int SLOTS     = 16;
  localparam int PORT_LSB  = 14;
  localparam int PORT_BITS = 6;
  localparam logic [31:0] PORT_FIELD = ((32'd1 << PORT_BITS) - 32'd1) << PORT_LSB;
  localparam int MAX_SHOWN = 10;

  typedef struct packed {
    ctpa_kind_e  kind;
    logic [31:0] ident;
    logic [31:0] mask;
    logic [3:0]  sel;
  } table_op_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we;
  logic [0:0] cfg_idx;
  logic [7:0] cfg_wdata;

  ctpa_in_if  req_ch ();
  ctpa_out_if rsp_ch ();

  connection_table_port_allocator_top #(
    .SLOTS     (SLOTS),
    .PORT_LSB  (PORT_LSB),
    .PORT_BITS (PORT_BITS)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (req_ch),
    .out_o       (rsp_ch)
  );

  // Local copy of the slot table and the allocator state
  bit          tbl_open [SLOTS];
  logic [31:0] tbl_ident [SLOTS];
  logic [3:0]  last_slot = '0;
  logic [7:0]  eph_port  = RST_NEXT_PORT;
  logic [7:0]  bind_max  = RST_MAX_BIND;
  logic [7:0]  top_port  = RST_PORT_LIMIT;

  table_op_t   pending_ops [$];
  ctpa_res_t   expected_replies [$];
  logic [31:0] ident_pool [$];

  int   ops_total    = 0;
  int   results_seen = 0;
  int   in_beats     = 0;
  int   errors       = 0;
  int   kind_seen [4];
  int   status_seen [4];
  int   hold_left    = 0;
  bit   hold_done    = 1'b0;
  logic req_took     = 1'b0;
  logic quiet;

  // no idling on either side for a stretch of beats
  assign quiet = (in_beats >= 600) && (in_beats < 850);

  function automatic logic [31:0] port_into(input logic [31:0] tmpl, input logic [7:0] port);
    return (tmpl & ~PORT_FIELD) | ((32'(port) << PORT_LSB) & PORT_FIELD);
  endfunction

  function automatic int match_slot(input logic [31:0] key, input logic [31:0] mask);
    for (int i = 0; i < SLOTS; i++)
      if (tbl_open[i] && ((tbl_ident[i] & mask) == (key & mask)))
        return i;
    return -1;
  endfunction

  // round robin from the slot after the last one given; that slot is skipped
  function automatic int claim_slot(input logic [31:0] id);
    int i;
    i = (last_slot + 1) % SLOTS;
    while (i != last_slot) begin
      if (!tbl_open[i]) begin
        tbl_open[i]  = 1'b1;
        tbl_ident[i] = id;
        last_slot    = i[3:0];
        return i;
      end
      i = (i + 1) % SLOTS;
    end
    return -1;
  endfunction

  function automatic ctpa_res_t apply_op(input table_op_t op);
    ctpa_res_t  res;
    logic [7:0] start;
    bit         found;
    int         hit;
    res.status = STAT_OK;
    res.slot   = '0;
    res.port   = '0;
    case (op.kind)
      KIND_FIND: begin
        hit = match_slot(op.ident, op.mask);
        if (hit < 0) res.status = STAT_NO_MATCH;
        else res.slot = hit[3:0];
      end
      KIND_OPEN: begin
        hit = claim_slot(op.ident);
        if (hit < 0) res.status = STAT_NO_SLOT;
        else res.slot = hit[3:0];
      end
      KIND_CONNECT: begin
        start = eph_port;
        found = 1'b0;
        for (int t = 0; t < MAX_TRIES; t++) begin
          eph_port = eph_port + 8'd1;
          if (eph_port == start) break;
          if (eph_port > top_port) eph_port = bind_max + 8'd1;
          if (match_slot(port_into(op.ident, eph_port), PORT_FIELD) < 0) begin
            found = 1'b1;
            break;
          end
        end
        res.port = eph_port;
        if (!found || eph_port == start) begin
          res.status = STAT_NO_PORT;
        end else begin
          hit = claim_slot(port_into(op.ident, eph_port));
          if (hit < 0) res.status = STAT_NO_SLOT;
          else res.slot = hit[3:0];
        end
      end
      default: begin
        if (op.sel < SLOTS) tbl_open[op.sel] = 1'b0;
        res.slot = op.sel;
      end
    endcase
    return res;
  endfunction

  task automatic queue_op(input ctpa_kind_e kind, input logic [31:0] ident,
                          input logic [31:0] mask, input logic [3:0] sel);
    pending_ops.push_back('{kind, ident, mask, sel});
    ops_total++;
  endtask

  task automatic queue_random_op(input int close_pct);
    int          r;
    logic [31:0] ident;
    logic [31:0] mask;
    ctpa_kind_e  kind;
    ident = $urandom;
    mask  = $urandom;
    r     = $urandom_range(99);
    if (r < close_pct) begin
      kind = KIND_CLOSE;
    end else if (r < close_pct + 25) begin
      kind = KIND_FIND;
      case ($urandom_range(3))
        0: mask = '0;
        1: begin
          if (ident_pool.size() != 0) ident = ident_pool[$urandom_range(ident_pool.size() - 1)];
          mask = ~PORT_FIELD;
        end
        2: begin
          if (ident_pool.size() != 0) ident = ident_pool[$urandom_range(ident_pool.size() - 1)];
        end
        default: ;
      endcase
    end else begin
      kind = (r < close_pct + 48) ? KIND_OPEN : KIND_CONNECT;
      ident_pool.push_back(ident);
      if (ident_pool.size() > 24) void'(ident_pool.pop_front());
    end
    queue_op(kind, ident, mask, 4'($urandom_range(15)));
  endtask

  task automatic write_reg(input ctpa_reg_e idx, input logic [7:0] value);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    if (idx == REG_MAX_BIND) bind_max = value;
    else top_port = value;
  endtask

  // every queued beat answered, then a short pause before touching registers
  task automatic settle();
    while (results_seen != ops_total) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = '0;
    cfg_wdata      = '0;
    req_ch.valid   = 1'b0;
    req_ch.kind    = '0;
    req_ch.ident   = '0;
    req_ch.match_mask = '0;
    req_ch.slot_sel = '0;
    rsp_ch.ready   = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #6000000;
    $display("connection_table_port_allocator_top: mismatch");
    $finish;
  end

  // request driver
  always @(negedge clk_i) begin : driver
    table_op_t next_op;
    if (rst_ni && (!req_ch.valid || req_took)) begin
      if (pending_ops.size() != 0 && (quiet || $urandom_range(99) >= 7)) begin
        next_op = pending_ops.pop_front();
        req_ch.valid      <= 1'b1;
        req_ch.kind       <= next_op.kind;
        req_ch.ident      <= next_op.ident;
        req_ch.match_mask <= next_op.mask;
        req_ch.slot_sel   <= next_op.sel;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off once traffic is flowing
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && in_beats >= 300) begin
      hold_left <= 200;
      hold_done <= 1'b1;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) rsp_ch.ready <= (hold_left == 0) && (quiet || $urandom_range(99) >= 7);
  end

  always @(posedge clk_i) begin : monitor
    table_op_t op;
    ctpa_res_t want;
    req_took <= req_ch.valid && req_ch.ready;
    if (rst_ni && req_ch.valid && req_ch.ready) begin
      op.kind  = ctpa_kind_e'(req_ch.kind);
      op.ident = req_ch.ident;
      op.mask  = req_ch.match_mask;
      op.sel   = req_ch.slot_sel;
      expected_replies.push_back(apply_op(op));
      kind_seen[req_ch.kind]++;
      in_beats <= in_beats + 1;
    end
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      results_seen++;
      if (expected_replies.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("%0t: reply beat with nothing outstanding: status %0d slot %0d port %0d",
                   $time, rsp_ch.status, rsp_ch.slot_out, rsp_ch.port_out);
      end else begin
        want = expected_replies.pop_front();
        status_seen[want.status]++;
        if (rsp_ch.status !== want.status || rsp_ch.slot_out !== want.slot ||
            rsp_ch.port_out !== want.port) begin
          errors++;
          if (errors <= MAX_SHOWN)
            $display("%0t: wrong reply: status %0d/%0d slot %0d/%0d port %0d/%0d (exp/got)",
                     $time, want.status, rsp_ch.status, want.slot, rsp_ch.slot_out,
                     want.port, rsp_ch.port_out);
        end
      end
    end
  end

  initial begin : stimulus
    int         phase_bind [7];
    int         phase_lim  [7];
    int         phase_len  [7];
    int         phase_cls  [7];
    logic [7:0] bind_val;
    logic [7:0] lim_val;
    phase_bind = '{0, 255, 40, -1, -1, -1, 31};
    phase_lim  = '{255, 0, 43, -1, -1, -1, 63};
    phase_len  = '{200, 150, 200, 200, 200, 200, 250};
    phase_cls  = '{25, 30, 25, 35, 35, 35, 20};
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty table, extremes of the fields, wrap and full table
    queue_op(KIND_FIND, '1, '1, 4'd0);
    queue_op(KIND_OPEN, '0, '0, 4'd0);
    queue_op(KIND_OPEN, '1, '1, 4'hF);
    queue_op(KIND_FIND, '0, '1, 4'd0);
    queue_op(KIND_FIND, '1, '0, 4'hF);
    queue_op(KIND_CONNECT, '0, '0, 4'd0);
    queue_op(KIND_CONNECT, '1, '1, 4'hF);
    queue_op(KIND_FIND, port_into('0, 8'd33), PORT_FIELD, 4'd0);
    queue_op(KIND_CLOSE, '1, '1, 4'hF);   // slot never opened
    queue_op(KIND_CLOSE, '0, '0, 4'd1);
    repeat (13) queue_op(KIND_OPEN, $urandom, $urandom, 4'($urandom_range(15)));
    queue_op(KIND_OPEN, 32'hA5A5_5A5A, '0, 4'd0);      // table full
    queue_op(KIND_CONNECT, 32'h5A5A_A5A5, '0, 4'd0);   // port found, no slot
    settle();

    for (int p = 0; p < 7; p++) begin
      if (phase_bind[p] < 0) begin
        bind_val = 8'($urandom_range(200));
        lim_val  = (p == 3) ? 8'($urandom_range(255)) : bind_val + 8'($urandom_range(50, 2));
      end else begin
        bind_val = 8'(phase_bind[p]);
        lim_val  = 8'(phase_lim[p]);
      end
      write_reg(REG_MAX_BIND, bind_val);
      write_reg(REG_PORT_LIMIT, lim_val);
      repeat (phase_len[p]) queue_random_op(phase_cls[p]);
      settle();
    end

    // a port search can run long; watch for stray beats
    repeat (600) @(negedge clk_i);
    errors += expected_replies.size();

    $display("Ran %0d beats (find %0d, open %0d, connect %0d, close %0d) over 8 register settings.",
             in_beats, kind_seen[KIND_FIND], kind_seen[KIND_OPEN], kind_seen[KIND_CONNECT],
             kind_seen[KIND_CLOSE]);
    $display("Replies: ok %0d, no match %0d, no free port %0d, no free slot %0d; errors %0d.",
             status_seen[STAT_OK], status_seen[STAT_NO_MATCH], status_seen[STAT_NO_PORT],
             status_seen[STAT_NO_SLOT], errors);
    if (errors == 0) begin
      $display("connection_table_port_allocator_top: match");
    end else begin
      $display("connection_table_port_allocator_top: mismatch");
    end
    $finish;
  end

endmodule
